[rtl/feistel32_cipher_modes_unit_defines.svh]
// assertion macros for the feistel cipher unit
`ifndef FEISTEL32_CIPHER_MODES_UNIT_DEFINES_SVH
`define FEISTEL32_CIPHER_MODES_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FCM_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fcm assertion failed");
`define FCM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fcm assertion failed");
`else
`define FCM_ASSERT_IMPL(label, ante, cons)
`define FCM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/fcm_pkg.sv]
// shared types, constants, round key and round functions of the feistel cipher unit
package fcm_pkg;

	localparam int ROUND_COUNT = 8;
	localparam int RND_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
	localparam int KEY_IDX_W = 3;
	localparam int ROT_AMOUNT = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam logic [31:0] IV_RESET = 32'h6174_6f64;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_SELECT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VECTOR = 3'd4;

	localparam logic [3:0] SBOX4 [16] = '{
		4'd3, 4'd5, 4'd4, 4'd8, 4'd9, 4'd1, 4'd11, 4'd13,
		4'd12, 4'd0, 4'd15, 4'd2, 4'd7, 4'd6, 4'd10, 4'd14
	};

	typedef enum logic [1:0] {
		MODE_RAW = 2'd0,
		MODE_ECB = 2'd1,
		MODE_CBC = 2'd2,
		MODE_CTR = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic [31:0] data_word;
		logic        restart;
	} item_t;

	function automatic logic [15:0] round_key(input logic [63:0] ku, input logic [63:0] kl,
		input logic [KEY_IDX_W-1:0] idx);
		logic [63:0] src;
		logic [15:0] k;
		src = idx[2] ? kl : ku;
		case (idx[1:0])
			2'd0: k = src[63:48];
			2'd1: k = src[47:32];
			2'd2: k = src[31:16];
			default: k = src[15:0];
		endcase
		return k;
	endfunction

	function automatic logic [15:0] round_f(input logic [15:0] left, input logic [15:0] k);
		logic [15:0] s;
		logic [3:0] nib;
		for (int i = 0; i < 4; i++) begin
			nib = left[4*i +: 4];
			s[4*i +: 4] = SBOX4[{nib[0], nib[1], nib[2], nib[3]}];
		end
		s = s ^ k;
		return {s[15-ROT_AMOUNT:0], s[15:16-ROT_AMOUNT]};
	endfunction

endpackage

[rtl/fcm_front.sv]
// input side: accepts transactions into a short queue ahead of the cipher core
module fcm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [31:0]    data_word,
	input  logic           restart,
	output logic           q_valid,
	output fcm_pkg::item_t q_item,
	input  logic           q_pop
);

	fcm_pkg::item_t                 mem_q [fcm_pkg::QUEUE_DEPTH];
	logic [fcm_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [fcm_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [fcm_pkg::QCNT_W-1:0]     cnt_q;
	logic                           push;
	logic                           pop;

	assign in_stall = (cnt_q == fcm_pkg::QCNT_W'(fcm_pkg::QUEUE_DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && q_valid;

	function automatic logic [fcm_pkg::QPTR_W-1:0] ptr_inc(input logic [fcm_pkg::QPTR_W-1:0] p);
		return (p == fcm_pkg::QPTR_W'(fcm_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data_word: data_word, restart: restart};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/fcm_core.sv]
// cipher core: configuration, chaining register, iterative feistel rounds, result register
`include "feistel32_cipher_modes_unit_defines.svh"

module fcm_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fcm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fcm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             q_valid,
	input  fcm_pkg::item_t                   q_item,
	output logic                             q_pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [31:0]                      result_word
);

	logic [63:0]                   key_upper_q;
	logic [63:0]                   key_lower_q;
	fcm_pkg::mode_t                mode_q;
	logic                          decrypt_q;
	logic [31:0]                   iv_q;
	logic [31:0]                   chain_q;

	fcm_pkg::state_t               state_q;
	fcm_pkg::state_t               state_d;
	logic [fcm_pkg::RND_W-1:0]     cnt_q;
	logic [15:0]                   l_q;
	logic [15:0]                   r_q;
	logic [31:0]                   x_q;
	logic                          out_valid_q;
	logic [31:0]                   result_q;

	logic                          inverse;
	logic [fcm_pkg::KEY_IDX_W-1:0] kidx;
	logic [15:0]                   f;
	logic                          last;
	logic                          out_free;
	logic                          finishing;
	logic                          start;
	logic [31:0]                   fin_word;
	logic [31:0]                   res;
	logic [31:0]                   chain_cur;
	logic [31:0]                   c_eff;
	logic [31:0]                   blk_in;
	logic [31:0]                   x_in;
	logic [31:0]                   chain_start;

	assign inverse = decrypt_q && (mode_q != fcm_pkg::MODE_CTR);
	assign kidx    = inverse ? (fcm_pkg::KEY_IDX_W'(fcm_pkg::ROUND_COUNT - 1)
		- fcm_pkg::KEY_IDX_W'(cnt_q)) : fcm_pkg::KEY_IDX_W'(cnt_q);
	assign f        = fcm_pkg::round_f(l_q, fcm_pkg::round_key(key_upper_q, key_lower_q, kidx));
	assign last     = (cnt_q == fcm_pkg::RND_W'(fcm_pkg::ROUND_COUNT - 1));
	assign out_free = !out_valid_q || !out_stall;
	assign fin_word = (state_q == fcm_pkg::ST_HOLD) ? {r_q, l_q} : {l_q, r_q ^ f};
	assign res      = (mode_q == fcm_pkg::MODE_RAW) ? x_q : (fin_word ^ x_q);

	assign chain_cur = (finishing && mode_q == fcm_pkg::MODE_CBC && !decrypt_q) ? res : chain_q;
	assign c_eff     = q_item.restart ? iv_q : chain_cur;
	assign q_pop     = start;

	always_comb begin
		case (mode_q)
			fcm_pkg::MODE_ECB: begin
				blk_in      = q_item.data_word;
				x_in        = '0;
				chain_start = c_eff;
			end
			fcm_pkg::MODE_CBC: begin
				if (decrypt_q) begin
					blk_in      = q_item.data_word;
					x_in        = c_eff;
					chain_start = q_item.data_word;
				end else begin
					blk_in      = q_item.data_word ^ c_eff;
					x_in        = '0;
					chain_start = c_eff;
				end
			end
			fcm_pkg::MODE_CTR: begin
				blk_in      = c_eff;
				x_in        = q_item.data_word;
				chain_start = c_eff + 32'd1;
			end
			default: begin
				blk_in      = q_item.data_word;
				x_in        = q_item.data_word;
				chain_start = c_eff;
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		finishing = 1'b0;
		start     = 1'b0;
		case (state_q)
			fcm_pkg::ST_IDLE: begin
				start = q_valid;
			end
			fcm_pkg::ST_RUN: begin
				if (last) begin
					finishing = out_free;
					start     = out_free && q_valid;
					state_d   = out_free ? fcm_pkg::ST_IDLE : fcm_pkg::ST_HOLD;
				end
			end
			fcm_pkg::ST_HOLD: begin
				finishing = out_free;
				start     = out_free && q_valid;
				if (out_free) begin
					state_d = fcm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fcm_pkg::ST_IDLE;
			end
		endcase
		if (start) begin
			state_d = fcm_pkg::ST_RUN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
			mode_q      <= fcm_pkg::MODE_RAW;
			decrypt_q   <= 1'b0;
			iv_q        <= fcm_pkg::IV_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fcm_pkg::REG_KEY_UPPER:      key_upper_q <= cfg_data;
				fcm_pkg::REG_KEY_LOWER:      key_lower_q <= cfg_data;
				fcm_pkg::REG_CIPHER_MODE:    mode_q      <= fcm_pkg::mode_t'(cfg_data[1:0]);
				fcm_pkg::REG_DECRYPT_SELECT: decrypt_q   <= cfg_data[0];
				fcm_pkg::REG_INITIAL_VECTOR: iv_q        <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fcm_pkg::ST_IDLE;
			cnt_q       <= '0;
			chain_q     <= fcm_pkg::IV_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				cnt_q   <= '0;
				chain_q <= chain_start;
			end else begin
				chain_q <= chain_cur;
				if (state_q == fcm_pkg::ST_RUN && !last) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (finishing) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			l_q <= blk_in[31:16];
			r_q <= blk_in[15:0];
			x_q <= x_in;
		end else if (state_q == fcm_pkg::ST_RUN) begin
			l_q <= r_q ^ f;
			r_q <= l_q;
		end
		if (finishing) begin
			result_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_word = result_q;

	`FCM_ASSERT_IMPL(a_hold_has_result, state_q == fcm_pkg::ST_HOLD, out_valid_q)
	`FCM_ASSERT_IMPL(a_start_needs_free, start && state_q != fcm_pkg::ST_IDLE, finishing)
	`FCM_ASSERT_NEXT(a_start_runs, start, state_q == fcm_pkg::ST_RUN && cnt_q == '0)
	`FCM_ASSERT_NEXT(a_finish_shows, finishing, out_valid_q)

endmodule

[rtl/feistel32_cipher_modes_unit.sv]
// Each 32-bit word is passed through unchanged in raw mode or goes through an 8-round
// Feistel cipher in ECB, CBC or CTR mode, one round per clock in a single shared round unit
// in the core; the next queued word starts in the cycle its predecessor finishes, so the
// core takes a new word only once the last one is through. A two-entry input queue keeps
// accepting until it is full while the core works, and a result register holds the finished
// word while the output is stalled; the core waits only when that register is still full at
// the end of the last round.
// Configuration writes take effect immediately and belong in idle periods; initial_vector
// reaches the chaining register only on a transaction with restart set, or at reset.
module feistel32_cipher_modes_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fcm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [31:0]                    data_word,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [31:0]                    result_word
);

	logic           q_valid;
	fcm_pkg::item_t q_item;
	logic           q_pop;

	fcm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_word (data_word),
		.restart   (restart),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	fcm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_word (result_word)
	);

endmodule
